@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the top RTL file of the handle directory.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, ignored while rst is high.
`define SOHD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication from a cause to an effect in the following cycle.
`define SOHD_ASSERT_NEXT(lbl, clk, rst, cause, effect, msg) \
   `SOHD_ASSERT(lbl, clk, rst, (cause) |=> (effect), msg)

`endif

@@ rtl/core/sohd_pkg.sv @@
`default_nettype none

package sohd_pkg;

   localparam int HANDLE_W = 16;
   localparam int OFFSET_W = 16;
   localparam int PAIR_W   = HANDLE_W + OFFSET_W;
   localparam int CSR_W    = 7;

   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_SET    = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_BAD_HANDLE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_STAT_RD,
      S_SRCH,
      S_SRCH_CHK,
      S_SHIFT,
      S_INS_WR
   } fsm_state_type;

   typedef struct packed {
      kind_type              kind;
      logic [HANDLE_W-1:0]   handle;
      logic [OFFSET_W-1:0]   offset;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic                  found;
      logic [OFFSET_W-1:0]   offset_out;
   } rsp_type;

   function automatic rsp_type make_rsp(input status_type st, input logic [OFFSET_W-1:0] ofs);
      rsp_type r;
      r.status     = st;
      r.found      = (ofs != '0);
      r.offset_out = ofs;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/sohd_ram.sv @@
`default_nettype none

module sohd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic                                    re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output      logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/sorted_handle_offset_directory_top.sv @@
// Channel   Ports                          Handshake
// request   start, busy, req_data          taken when start is high and busy low
// response  rsp_valid, rsp_data            one cycle strobe, cannot be held off
// csr       csr_we, csr_wdata              written when csr_we is high
//
// A bad handle or static set is answered from idle, a static lookup via a read state;
// a dynamic lookup takes a search and check state per probe of the pair memory and one
// more search state when the handle is absent. An insert adds to that miss a shift
// state per pair moved and one to write the new pair. Reset and every clear sweep the
// static slot memory with busy high. The response is registered and appears the cycle
// after the item finishes; the receiver cannot stall and never holds an item back.
`default_nettype none

`include "assert_macros.svh"

module sorted_handle_offset_directory_top #(
   parameter int STATIC_MAX = 64,
   parameter int DYN_DEPTH  = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire sohd_pkg::req_type            req_data,
   output      logic                         rsp_valid,
   output      sohd_pkg::rsp_type            rsp_data,
   input  wire logic                         csr_we,
   input  wire logic [sohd_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int SAW = (STATIC_MAX > 1) ? $clog2(STATIC_MAX) : 1;
   localparam int DAW = $clog2(DYN_DEPTH);
   localparam int CW  = $clog2(DYN_DEPTH + 1);
   localparam int HW  = sohd_pkg::HANDLE_W;
   localparam int OW  = sohd_pkg::OFFSET_W;
   localparam int PW  = sohd_pkg::PAIR_W;

   sohd_pkg::fsm_state_type state_ff, state_in;
   logic [sohd_pkg::CSR_W-1:0] csr_ff, csr_in;
   sohd_pkg::req_type          req_ff, req_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              lo_ff, lo_in;
   logic [CW-1:0]              hi_ff, hi_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              mid_ff, mid_in;
   logic [SAW-1:0]             clr_ff, clr_in;
   logic                       clr_rsp_ff, clr_rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   sohd_pkg::rsp_type          rsp_ff, rsp_in;

   logic            st_we, st_re;
   logic [SAW-1:0]  st_waddr, st_raddr;
   logic [OW-1:0]   st_wdata, st_rdata;
   logic            dyn_we, dyn_re;
   logic [DAW-1:0]  dyn_waddr, dyn_raddr;
   logic [PW-1:0]   dyn_wdata, dyn_rdata;

   logic [HW-1:0]   scount;
   logic [CW-1:0]   mid_w;
   logic [CW-1:0]   last_w;
   logic [HW-1:0]   key_w;

   sohd_ram #(.WIDTH(OW), .DEPTH(STATIC_MAX)) u_static_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .re    (st_re),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   sohd_ram #(.WIDTH(PW), .DEPTH(DYN_DEPTH)) u_pair_ram (
      .clock (clock),
      .we    (dyn_we),
      .waddr (dyn_waddr),
      .wdata (dyn_wdata),
      .re    (dyn_re),
      .raddr (dyn_raddr),
      .rdata (dyn_rdata)
   );

   // Static handles in use, saturated at the number of slots.
   assign scount = (HW'(csr_ff) > HW'(STATIC_MAX)) ? HW'(STATIC_MAX) : HW'(csr_ff);
   assign mid_w  = CW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign last_w = count_ff - CW'(1);
   assign key_w  = dyn_rdata[PW-1:OW];

   assign busy      = (state_ff != sohd_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sohd_pkg::S_CLEAR;
         csr_ff       <= '0;
         count_ff     <= '0;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      idx_ff <= idx_in;
      mid_ff <= mid_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      csr_in       = csr_we ? csr_wdata : csr_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      mid_in       = mid_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      st_we     = 1'b0;
      st_waddr  = clr_ff;
      st_wdata  = '0;
      st_re     = 1'b0;
      st_raddr  = SAW'(req_data.handle - HW'(1));
      dyn_we    = 1'b0;
      dyn_waddr = mid_ff[DAW-1:0];
      dyn_wdata = {req_ff.handle, req_ff.offset};
      dyn_re    = 1'b0;
      dyn_raddr = mid_w[DAW-1:0];

      unique case (state_ff)
         sohd_pkg::S_CLEAR: begin
            st_we = 1'b1;
            if (clr_ff == SAW'(STATIC_MAX - 1)) begin
               state_in   = sohd_pkg::S_IDLE;
               clr_in     = '0;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = sohd_pkg::make_rsp(sohd_pkg::ST_OK, '0);
               end
            end else begin
               clr_in = clr_ff + SAW'(1);
            end
         end

         sohd_pkg::S_IDLE: begin
            if (start) begin
               req_in = req_data;
               unique case (req_data.kind)
                  sohd_pkg::KIND_CLEAR: begin
                     count_in   = '0;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = sohd_pkg::S_CLEAR;
                  end
                  sohd_pkg::KIND_LOOKUP, sohd_pkg::KIND_SET: begin
                     if (req_data.handle == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = sohd_pkg::make_rsp(sohd_pkg::ST_BAD_HANDLE, '0);
                     end else if (req_data.handle <= scount) begin
                        if (req_data.kind == sohd_pkg::KIND_LOOKUP) begin
                           st_re    = 1'b1;
                           state_in = sohd_pkg::S_STAT_RD;
                        end else begin
                           st_we        = 1'b1;
                           st_waddr     = SAW'(req_data.handle - HW'(1));
                           st_wdata     = req_data.offset;
                           rsp_valid_in = 1'b1;
                           rsp_in       = sohd_pkg::make_rsp(sohd_pkg::ST_OK, '0);
                        end
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        state_in = sohd_pkg::S_SRCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = sohd_pkg::make_rsp(sohd_pkg::ST_OK, '0);
                  end
               endcase
            end
         end

         sohd_pkg::S_STAT_RD: begin
            rsp_valid_in = 1'b1;
            rsp_in       = sohd_pkg::make_rsp(sohd_pkg::ST_OK, st_rdata);
            state_in     = sohd_pkg::S_IDLE;
         end

         sohd_pkg::S_SRCH: begin
            if (lo_ff < hi_ff) begin
               dyn_re   = 1'b1;
               mid_in   = mid_w;
               state_in = sohd_pkg::S_SRCH_CHK;
            end else if (req_ff.kind == sohd_pkg::KIND_LOOKUP) begin
               rsp_valid_in = 1'b1;
               rsp_in       = sohd_pkg::make_rsp(sohd_pkg::ST_OK, '0);
               state_in     = sohd_pkg::S_IDLE;
            end else if (count_ff == CW'(DYN_DEPTH)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = sohd_pkg::make_rsp(sohd_pkg::ST_FULL, '0);
               state_in     = sohd_pkg::S_IDLE;
            end else if (lo_ff == count_ff) begin
               state_in = sohd_pkg::S_INS_WR;
            end else begin
               // Move pairs up from the top down, one read and one write a cycle.
               dyn_re    = 1'b1;
               dyn_raddr = last_w[DAW-1:0];
               idx_in    = last_w;
               state_in  = sohd_pkg::S_SHIFT;
            end
         end

         sohd_pkg::S_SRCH_CHK: begin
            if (key_w == req_ff.handle) begin
               rsp_valid_in = 1'b1;
               state_in     = sohd_pkg::S_IDLE;
               if (req_ff.kind == sohd_pkg::KIND_LOOKUP) begin
                  rsp_in = sohd_pkg::make_rsp(sohd_pkg::ST_OK, dyn_rdata[OW-1:0]);
               end else begin
                  dyn_we = 1'b1;
                  rsp_in = sohd_pkg::make_rsp(sohd_pkg::ST_OK, '0);
               end
            end else begin
               if (key_w > req_ff.handle) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + CW'(1);
               end
               state_in = sohd_pkg::S_SRCH;
            end
         end

         sohd_pkg::S_SHIFT: begin
            dyn_we    = 1'b1;
            dyn_waddr = DAW'(idx_ff + CW'(1));
            dyn_wdata = dyn_rdata;
            if (idx_ff == lo_ff) begin
               state_in = sohd_pkg::S_INS_WR;
            end else begin
               dyn_re    = 1'b1;
               dyn_raddr = DAW'(idx_ff - CW'(1));
               idx_in    = idx_ff - CW'(1);
            end
         end

         sohd_pkg::S_INS_WR: begin
            dyn_we       = 1'b1;
            dyn_waddr    = lo_ff[DAW-1:0];
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            rsp_in       = sohd_pkg::make_rsp(sohd_pkg::ST_OK, '0);
            state_in     = sohd_pkg::S_IDLE;
         end

         default: begin
            state_in = sohd_pkg::S_IDLE;
         end
      endcase
   end

   `SOHD_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DYN_DEPTH), "pair count beyond depth")
   `SOHD_ASSERT(a_rsp_when_idle, clock, reset,
      !rsp_valid_ff || state_ff == sohd_pkg::S_IDLE, "response while busy")
   `SOHD_ASSERT(a_shift_range, clock, reset,
      state_ff != sohd_pkg::S_SHIFT || (idx_ff >= lo_ff && idx_ff < count_ff),
      "shift index out of range")
   `SOHD_ASSERT(a_pair_wr_range, clock, reset,
      !dyn_we || CW'(dyn_waddr) <= count_ff, "pair write above the count")
   `SOHD_ASSERT_NEXT(a_clear_sweep, clock, reset,
      start && !busy && req_data.kind == sohd_pkg::KIND_CLEAR,
      state_ff == sohd_pkg::S_CLEAR && count_ff == '0, "clear did not start a sweep")

endmodule

`default_nettype wire
